// ----- hw/rtl/dsps_pkg.sv -----
// Package for the dual servo pulse generator: item types, command codes, register indexes.
package dsps_pkg;

  localparam int unsigned WidthW = 16;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 3;

  localparam logic [WidthW-1:0] RESET_FRAME_LENGTH = 16'd20000;
  localparam logic [WidthW-1:0] RESET_MIN_WIDTH    = 16'd1000;
  localparam logic [WidthW-1:0] RESET_MAX_WIDTH    = 16'd2000;
  localparam logic [WidthW-1:0] RESET_JOG_STEP     = 16'd110;
  localparam logic [WidthW-1:0] RESET_SLEW_STEP    = 16'd2;
  localparam logic [WidthW-1:0] RESET_POSITION     = 16'd1500;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  localparam logic [CodeW-1:0] CMD_TILT_DOWN = 4'd0;
  localparam logic [CodeW-1:0] CMD_TILT_UP   = 4'd1;
  localparam logic [CodeW-1:0] CMD_TILT_MIN  = 4'd2;
  localparam logic [CodeW-1:0] CMD_TILT_MAX  = 4'd3;
  localparam logic [CodeW-1:0] CMD_PAN_DOWN  = 4'd4;
  localparam logic [CodeW-1:0] CMD_PAN_UP    = 4'd5;
  localparam logic [CodeW-1:0] CMD_PAN_MIN   = 4'd6;
  localparam logic [CodeW-1:0] CMD_PAN_MAX   = 4'd7;

  localparam logic [RegIdxW-1:0] REG_FRAME_LENGTH = 3'd0;
  localparam logic [RegIdxW-1:0] REG_MIN_WIDTH    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_MAX_WIDTH    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_JOG_STEP     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SLEW_STEP    = 3'd4;

  typedef struct packed {
    logic             mode;
    logic [CodeW-1:0] command;
  } in_item_t;

  typedef struct packed {
    logic              tilt_pin;
    logic              pan_pin;
    logic [WidthW-1:0] tilt_width;
    logic [WidthW-1:0] pan_width;
    logic              bad_command;
  } out_item_t;

endpackage

// ----- hw/rtl/dual_servo_pwm_slew_top.sv -----
// Dual servo pulse generator with slew limit: APB registers, state update, output skid buffer.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | in_item: mode, command
//  out     | out_valid/ out_ready | out_item: tilt_pin, pan_pin, tilt_width,
//          |                      |           pan_width, bad_command
//  cfg     | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One item per cycle while in_ready is high; state updates at the accept edge.
// The result goes to the output register, or to the skid register on a stall.
// A two-entry output stage (result register plus skid register) lets in_ready come
// from a flop; input stalls only when both entries are full.
// Reset is synchronous and restores register defaults, widths 1500 and counter 0.
module dual_servo_pwm_slew_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dsps_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dsps_pkg::out_item_t            out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dsps_pkg::AddrW-1:0]     paddr,
  input  logic [dsps_pkg::DataW-1:0]     pwdata,
  output logic [dsps_pkg::DataW-1:0]     prdata,
  output logic                           pready
);
  import dsps_pkg::*;

  logic [WidthW-1:0] frame_length, min_width, max_width, jog_step, slew_step;
  logic [WidthW-1:0] tilt_now, tilt_goal, pan_now, pan_goal, frame_count;
  logic [WidthW-1:0] tilt_now_next, tilt_goal_next, pan_now_next, pan_goal_next;
  logic [WidthW-1:0] frame_count_next;
  logic [RegIdxW-1:0] reg_idx;
  logic               cfg_write;
  logic               in_accept;
  logic               frame_end;
  logic [WidthW:0]    count_inc;
  logic [WidthW-1:0]  tilt_slew, pan_slew, tilt_down, tilt_up, pan_down, pan_up;
  logic               bad;
  out_item_t          result;
  out_item_t          skid_item;
  logic               skid_valid;

  function automatic logic [WidthW-1:0] slew_toward(
    input logic [WidthW-1:0] now,
    input logic [WidthW-1:0] goal,
    input logic [WidthW-1:0] step
  );
    logic [WidthW-1:0] gap_up;
    logic [WidthW-1:0] gap_dn;
    logic [WidthW-1:0] res;
    gap_up = goal - now;
    gap_dn = now - goal;
    if (now < goal) begin
      res = (gap_up < step) ? goal : now + step;
    end else if (now > goal) begin
      res = (gap_dn < step) ? goal : now - step;
    end else begin
      res = now;
    end
    return res;
  endfunction

  function automatic logic [WidthW-1:0] nudge_down(
    input logic [WidthW-1:0] goal,
    input logic [WidthW-1:0] jog,
    input logic [WidthW-1:0] lo
  );
    logic [WidthW:0]   diff;
    logic [WidthW-1:0] res;
    diff = {1'b0, goal} - {1'b0, jog};
    if (diff[WidthW] || (diff[WidthW-1:0] < lo)) begin
      res = lo;
    end else begin
      res = diff[WidthW-1:0];
    end
    return res;
  endfunction

  function automatic logic [WidthW-1:0] nudge_up(
    input logic [WidthW-1:0] goal,
    input logic [WidthW-1:0] jog,
    input logic [WidthW-1:0] hi
  );
    logic [WidthW:0]   sum;
    logic [WidthW-1:0] res;
    sum = {1'b0, goal} + {1'b0, jog};
    if (sum > {1'b0, hi}) begin
      res = hi;
    end else begin
      res = sum[WidthW-1:0];
    end
    return res;
  endfunction

  // configuration port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[AddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= RESET_FRAME_LENGTH;
      min_width    <= RESET_MIN_WIDTH;
      max_width    <= RESET_MAX_WIDTH;
      jog_step     <= RESET_JOG_STEP;
      slew_step    <= RESET_SLEW_STEP;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_FRAME_LENGTH: frame_length <= pwdata[WidthW-1:0];
        REG_MIN_WIDTH:    min_width    <= pwdata[WidthW-1:0];
        REG_MAX_WIDTH:    max_width    <= pwdata[WidthW-1:0];
        REG_JOG_STEP:     jog_step     <= pwdata[WidthW-1:0];
        REG_SLEW_STEP:    slew_step    <= pwdata[WidthW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FRAME_LENGTH: prdata = {{(DataW-WidthW){1'b0}}, frame_length};
      REG_MIN_WIDTH:    prdata = {{(DataW-WidthW){1'b0}}, min_width};
      REG_MAX_WIDTH:    prdata = {{(DataW-WidthW){1'b0}}, max_width};
      REG_JOG_STEP:     prdata = {{(DataW-WidthW){1'b0}}, jog_step};
      REG_SLEW_STEP:    prdata = {{(DataW-WidthW){1'b0}}, slew_step};
      default:          prdata = '0;
    endcase
  end

  // item update
  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign count_inc = {1'b0, frame_count} + {{WidthW{1'b0}}, 1'b1};
  assign frame_end = count_inc >= {1'b0, frame_length};

  assign tilt_slew = slew_toward(tilt_now, tilt_goal, slew_step);
  assign pan_slew  = slew_toward(pan_now, pan_goal, slew_step);
  assign tilt_down = nudge_down(tilt_goal, jog_step, min_width);
  assign tilt_up   = nudge_up(tilt_goal, jog_step, max_width);
  assign pan_down  = nudge_down(pan_goal, jog_step, min_width);
  assign pan_up    = nudge_up(pan_goal, jog_step, max_width);

  always_comb begin
    frame_count_next = frame_count;
    tilt_now_next    = tilt_now;
    pan_now_next     = pan_now;
    tilt_goal_next   = tilt_goal;
    pan_goal_next    = pan_goal;
    bad              = 1'b0;
    if (in_item.mode == MODE_TICK) begin
      if (frame_end) begin
        frame_count_next = '0;
        tilt_now_next    = tilt_slew;
        pan_now_next     = pan_slew;
      end else begin
        frame_count_next = count_inc[WidthW-1:0];
      end
    end else begin
      unique case (in_item.command)
        CMD_TILT_DOWN: tilt_goal_next = tilt_down;
        CMD_TILT_UP:   tilt_goal_next = tilt_up;
        CMD_TILT_MIN:  tilt_goal_next = min_width;
        CMD_TILT_MAX:  tilt_goal_next = max_width;
        CMD_PAN_DOWN:  pan_goal_next  = pan_down;
        CMD_PAN_UP:    pan_goal_next  = pan_up;
        CMD_PAN_MIN:   pan_goal_next  = min_width;
        CMD_PAN_MAX:   pan_goal_next  = max_width;
        default:       bad            = 1'b1;
      endcase
    end
    result.tilt_pin    = frame_count < tilt_now;
    result.pan_pin     = frame_count < pan_now;
    result.tilt_width  = tilt_now_next;
    result.pan_width   = pan_now_next;
    result.bad_command = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      tilt_now    <= RESET_POSITION;
      tilt_goal   <= RESET_POSITION;
      pan_now     <= RESET_POSITION;
      pan_goal    <= RESET_POSITION;
    end else if (in_accept) begin
      frame_count <= frame_count_next;
      tilt_now    <= tilt_now_next;
      tilt_goal   <= tilt_goal_next;
      pan_now     <= pan_now_next;
      pan_goal    <= pan_goal_next;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (in_accept) begin
        out_item <= result;
      end
    end else if (in_accept) begin
      skid_item <= result;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while result register empty");

  a_command_keeps_position: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !rst && in_item.mode == MODE_COMMAND) |=>
      ($stable(tilt_now) && $stable(pan_now) && $stable(frame_count)))
    else $error("command item moved a width or the frame counter");

  a_tick_keeps_goals: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !rst && in_item.mode == MODE_TICK) |=>
      ($stable(tilt_goal) && $stable(pan_goal)))
    else $error("tick item changed a target width");

  a_counter_in_frame: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !rst && in_item.mode == MODE_TICK && !frame_end) |=>
      (frame_count < $past(frame_length)))
    else $error("frame counter reached frame length without wrapping");

endmodule
